// File: rtl/jse_pkg.sv
// Shared types, character codes and helper functions for the JSON string escaper.
`timescale 1ns / 1ps

package jse_pkg;

    // Width of one string byte.
    localparam int BYTE_W = 8;
    // Width of a packed code point.
    localparam int CODE_W = 16;
    // Width of the byte index within a run of escape output.
    localparam int IDX_W = 3;

    // Kinds of output run that one input word can cause.
    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_ESCAPE  = 2'd1;
    localparam logic [1:0] KIND_UNICODE = 2'd2;

    // Index of the last byte of an escape run and of a unicode escape run.
    localparam logic [IDX_W-1:0] IDX_ESC_LAST = 3'd1;
    localparam logic [IDX_W-1:0] IDX_UNI_LAST = 3'd5;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHR_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CHR_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_FORMFEED  = 8'h0C;
    localparam logic [BYTE_W-1:0] CHR_RETURN    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CHR_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CHR_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHR_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CHR_LOWER_B   = 8'h62;
    localparam logic [BYTE_W-1:0] CHR_LOWER_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CHR_LOWER_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] CHR_LOWER_R   = 8'h72;
    localparam logic [BYTE_W-1:0] CHR_LOWER_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CHR_LOWER_U   = 8'h75;
    localparam logic [BYTE_W-1:0] CHR_TILDE     = 8'h7E;

    // One pending output run: its kind, a plain or escape character, and a code point.
    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] chr;
        logic [CODE_W-1:0] code;
    } t_run;

    // Escape letter for a byte, or NUL when the byte passes through unchanged.
    function automatic logic [BYTE_W-1:0] escape_letter(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] letter;
        case (b)
            CHR_QUOTE:     letter = CHR_QUOTE;
            CHR_NEWLINE:   letter = CHR_LOWER_N;
            CHR_RETURN:    letter = CHR_LOWER_R;
            CHR_TAB:       letter = CHR_LOWER_T;
            CHR_BACKSPACE: letter = CHR_LOWER_B;
            CHR_FORMFEED:  letter = CHR_LOWER_F;
            CHR_BACKSLASH: letter = CHR_BACKSLASH;
            CHR_SLASH:     letter = CHR_SLASH;
            default:       letter = CHR_NUL;
        endcase
        return letter;
    endfunction

    // Lowercase hex digit for one nibble.
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
        logic [BYTE_W-1:0] d;
        if (n < 4'd10) begin
            d = CHR_ZERO + {4'd0, n};
        end else begin
            d = CHR_LOWER_A + {4'd0, n} - 8'd10;
        end
        return d;
    endfunction

endpackage

// File: rtl/jse_seq.sv
// Byte classifier and multi-byte sequence gatherer that builds at most one output run per word.
`timescale 1ns / 1ps

module jse_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [jse_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eos,
    output logic                       o_has_run,
    output jse_pkg::t_run              o_run
);
    import jse_pkg::*;

    logic [1:0]        r_gathered;
    logic [1:0]        r_seq_len;
    logic [BYTE_W-1:0] r_b0;
    logic [BYTE_W-1:0] r_b1;

    logic [1:0]        n_gathered;
    logic [1:0]        n_seq_len;
    logic [1:0]        lead_len;
    logic [1:0]        len_eff;
    logic [BYTE_W-1:0] b0_eff;
    logic [BYTE_W-1:0] b1_eff;
    logic [BYTE_W-1:0] letter;
    logic [CODE_W-1:0] code;
    logic              is_ascii;
    logic              complete;

    // Sequence length from the lead byte: set bits among its top three bits.
    assign lead_len = {1'b0, i_byte[7]} + {1'b0, i_byte[6]} + {1'b0, i_byte[5]};
    assign len_eff  = (r_gathered == 2'd0) ? lead_len : r_seq_len;
    assign b0_eff   = (r_gathered == 2'd0) ? i_byte : r_b0;
    assign b1_eff   = (r_gathered == 2'd1) ? i_byte : r_b1;
    assign complete = ({1'b0, r_gathered} + 3'd1) >= {1'b0, len_eff};
    assign is_ascii = i_byte <= CHR_TILDE;
    assign letter   = escape_letter(i_byte);

    // Pack the payload bits into a code point; the current byte is always the last one.
    always_comb begin
        case (len_eff)
            2'd1:    code = {9'd0, b0_eff[6:0]};
            2'd2:    code = {5'd0, b0_eff[4:0], b1_eff[5:0]};
            default: code = {b0_eff[3:0], b1_eff[5:0], i_byte[5:0]};
        endcase
    end

    // Describe the run of output bytes that this word causes.
    always_comb begin
        o_run.code = code;
        o_run.chr  = i_byte;
        o_run.kind = KIND_PLAIN;
        o_has_run  = 1'b0;
        if (i_byte == CHR_NUL) begin
            o_has_run = 1'b0;
        end else if (is_ascii) begin
            o_has_run = 1'b1;
            if (letter != CHR_NUL) begin
                o_run.kind = KIND_ESCAPE;
                o_run.chr  = letter;
            end
        end else begin
            o_has_run  = complete;
            o_run.kind = KIND_UNICODE;
        end
    end

    // Next sequence state; the end of a string drops whatever is pending.
    always_comb begin
        n_gathered = r_gathered;
        n_seq_len  = r_seq_len;
        if (i_byte != CHR_NUL && !is_ascii) begin
            if (r_gathered == 2'd0) begin
                n_seq_len = lead_len;
            end
            n_gathered = complete ? 2'd0 : r_gathered + 2'd1;
        end
        if (i_eos) begin
            n_gathered = 2'd0;
            n_seq_len  = 2'd0;
        end
    end

    // Sequence control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gathered <= 2'd0;
            r_seq_len  <= 2'd0;
        end else if (i_step) begin
            r_gathered <= n_gathered;
            r_seq_len  <= n_seq_len;
        end
    end

    // Stored bytes of the pending sequence.
    always_ff @(posedge i_clk) begin
        if (i_step && i_byte != CHR_NUL && !is_ascii) begin
            if (r_gathered == 2'd0) begin
                r_b0 <= i_byte;
            end
            if (r_gathered == 2'd1) begin
                r_b1 <= i_byte;
            end
        end
    end

endmodule

// File: rtl/jse_serial.sv
// Run register and output register that send one escaped byte per word.
`timescale 1ns / 1ps

module jse_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  jse_pkg::t_run              i_run,
    output logic                       o_free,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [jse_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last_of_run
);
    import jse_pkg::*;

    t_run              r_run;
    logic              r_run_valid;
    logic [IDX_W-1:0]  r_idx;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_last;

    logic              o_load;
    logic              cur_last;
    logic [BYTE_W-1:0] cur_byte;

    // Select the byte at the current index of the run.
    always_comb begin
        cur_byte = r_run.chr;
        cur_last = 1'b1;
        case (r_run.kind)
            KIND_PLAIN: begin
                cur_byte = r_run.chr;
                cur_last = 1'b1;
            end
            KIND_ESCAPE: begin
                cur_byte = (r_idx == 3'd0) ? CHR_BACKSLASH : r_run.chr;
                cur_last = r_idx == IDX_ESC_LAST;
            end
            KIND_UNICODE: begin
                cur_last = r_idx == IDX_UNI_LAST;
                case (r_idx)
                    3'd0:    cur_byte = CHR_BACKSLASH;
                    3'd1:    cur_byte = CHR_LOWER_U;
                    3'd2:    cur_byte = hex_digit(r_run.code[15:12]);
                    3'd3:    cur_byte = hex_digit(r_run.code[11:8]);
                    3'd4:    cur_byte = hex_digit(r_run.code[7:4]);
                    default: cur_byte = hex_digit(r_run.code[3:0]);
                endcase
            end
            default: begin
                cur_byte = r_run.chr;
                cur_last = 1'b1;
            end
        endcase
    end

    assign o_load = r_run_valid && (!r_o_valid || i_ready);
    assign o_free = !r_run_valid || (o_load && cur_last);

    // Run register and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (o_load && cur_last) begin
                r_run_valid <= 1'b0;
                r_idx       <= '0;
            end else if (o_load) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_load) begin
                r_run_valid <= 1'b1;
                r_idx       <= '0;
            end
        end
    end

    // Run payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_byte <= cur_byte;
            r_o_last <= cur_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_last_of_run = r_o_last;

endmodule

// File: rtl/json_string_escaper_top.sv
// Top level of the JSON string escaper: input register, sequence gatherer and serializer.
`timescale 1ns / 1ps

// The escaper takes one string byte per word and sends its JSON-escaped form one byte
// per word, with o_last_of_run high on the final byte caused by each input word. Plain
// ASCII words flow at one word per cycle while i_ready is high, through the input register,
// run register and output register. A word that causes several output bytes holds the
// serializer until its last byte is loaded, as a two-byte escape or a completed multi-byte
// sequence (a six-byte unicode escape) does; NUL words and the non-final bytes of a sequence
// cause no output. The serializer's one-byte-per-cycle output register, stalled by a low i_ready, sets the rate.
module json_string_escaper_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [jse_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_end_of_string,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [jse_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last_of_run
);
    import jse_pkg::*;

    logic              r_a_valid;
    logic [BYTE_W-1:0] r_a_byte;
    logic              r_a_eos;

    logic              a_step;
    logic              run_free;
    logic              has_run;
    t_run              run;

    assign a_step  = r_a_valid && run_free;
    assign o_ready = !r_a_valid || a_step;

    // Input register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_a_valid <= 1'b1;
        end else if (a_step) begin
            r_a_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_byte <= i_in_byte;
            r_a_eos  <= i_end_of_string;
        end
    end

    // Classify the word and gather multi-byte sequences.
    jse_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (a_step),
        .i_byte    (r_a_byte),
        .i_eos     (r_a_eos),
        .o_has_run (has_run),
        .o_run     (run)
    );

    // Send the run one byte at a time.
    jse_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (a_step && has_run),
        .i_run         (run),
        .o_free        (run_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

`ifndef ASSERT_OFF
    // A waiting output word holds steady until it is taken.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("output word changed while waiting");

    // A NUL word never starts an output run.
    a_nul_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_step && r_a_byte == CHR_NUL) |-> !has_run)
        else $error("NUL word produced an output run");

    // Reset leaves no output word pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

// File: bench/tb.sv
// Self-checking testbench for the JSON string escaper top level.
`timescale 1ns / 1ps

module tb;
    import jse_pkg::*;

    // Run limits and the receiver's long hold-off.
    localparam int RANDOM_WORDS = 155;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 20;
    localparam int LIMIT        = 200000;

    // One string byte waiting to be sent; drain asks the sender to wait for all output first.
    typedef struct packed {
        logic [BYTE_W-1:0] chr;
        logic              eos;
        logic              drain;
    } string_word_t;

    // One escaped output byte as it should appear on the result channel.
    typedef struct packed {
        logic [BYTE_W-1:0] chr;
        logic              last;
    } escaped_word_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_in_byte = CHR_LOWER_A;
    logic              i_end_of_string = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last_of_run;

    string_word_t  string_q[$];
    escaped_word_t escaped_q[$];

    // Shadow copy of the escaper's sequence gatherer.
    logic [1:0]        seq_got = 2'd0;
    logic [1:0]        seq_len = 2'd0;
    logic [BYTE_W-1:0] seq_buf [3] = '{default: '0};
    string             hex_set = "0123456789abcdef";

    int errors      = 0;
    int cycle_count = 0;
    int words_in    = 0;
    int words_owed  = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int ready_mode  = 0;
    int mode_left   = 0;

    json_string_escaper_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Prints one failure line and counts it.
    task automatic flag_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    // Works out the escaped bytes for one accepted word and queues them.
    function automatic void escape_byte(input logic [BYTE_W-1:0] b, input logic eos);
        logic [BYTE_W-1:0] run [6];
        logic [BYTE_W-1:0] letter;
        logic [CODE_W-1:0] cp;
        int                n;
        n = 0;
        case (b)
            CHR_QUOTE:     letter = CHR_QUOTE;
            CHR_NEWLINE:   letter = CHR_LOWER_N;
            CHR_RETURN:    letter = CHR_LOWER_R;
            CHR_TAB:       letter = CHR_LOWER_T;
            CHR_BACKSPACE: letter = CHR_LOWER_B;
            CHR_FORMFEED:  letter = CHR_LOWER_F;
            CHR_BACKSLASH: letter = CHR_BACKSLASH;
            CHR_SLASH:     letter = CHR_SLASH;
            default:       letter = CHR_NUL;
        endcase
        if (b != CHR_NUL && b <= CHR_TILDE) begin
            // ASCII passes through or becomes a two-byte escape, even inside a sequence.
            if (letter != CHR_NUL) begin
                run[0] = CHR_BACKSLASH;
                run[1] = letter;
                n = 2;
            end else begin
                run[0] = b;
                n = 1;
            end
        end else if (b > CHR_TILDE) begin
            // A lead byte sets the length from its top three bits; later bytes just fill in.
            if (seq_got == 2'd0) begin
                seq_len = 2'(b[7]) + 2'(b[6]) + 2'(b[5]);
                seq_buf = '{default: '0};
            end
            if (seq_got < 2'd3) begin
                seq_buf[seq_got] = b;
            end
            seq_got = seq_got + 2'd1;
            if (seq_got >= seq_len) begin
                case (seq_len)
                    2'd1:    cp = {9'd0, seq_buf[0][6:0]};
                    2'd2:    cp = {5'd0, seq_buf[0][4:0], seq_buf[1][5:0]};
                    default: cp = {seq_buf[0][3:0], seq_buf[1][5:0], seq_buf[2][5:0]};
                endcase
                run[0] = CHR_BACKSLASH;
                run[1] = CHR_LOWER_U;
                run[2] = BYTE_W'(hex_set[cp[15:12]]);
                run[3] = BYTE_W'(hex_set[cp[11:8]]);
                run[4] = BYTE_W'(hex_set[cp[7:4]]);
                run[5] = BYTE_W'(hex_set[cp[3:0]]);
                n = 6;
                seq_got = 2'd0;
            end
        end
        // End of string drops whatever is left of a sequence.
        if (eos) begin
            seq_got = 2'd0;
            seq_len = 2'd0;
        end
        for (int k = 0; k < n; k++) begin
            escaped_q.push_back('{chr: run[k], last: (k == n - 1)});
        end
    endfunction

    // Queues one string byte for the sender.
    function automatic void add_word(input logic [BYTE_W-1:0] chr, input logic eos,
                                     input logic drain);
        string_q.push_back('{chr: chr, eos: eos, drain: drain});
    endfunction

    // Sender: offers words in bursts with random gaps, and waits out a drain request.
    always @(posedge i_clk) begin : sender
        string_word_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (string_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (string_q[0].drain && (i_valid || words_owed != 0)) begin
                i_valid <= 1'b0;
            end else if (gap_left != 0 && hold_left == 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else begin
                nxt = string_q.pop_front();
                i_valid <= 1'b1;
                i_in_byte <= nxt.chr;
                i_end_of_string <= nxt.eos;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: stalls on changing patterns, and once holds off for a long stretch.
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(5, 40);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: predicts on each accepted input word and checks each accepted output word.
    always @(posedge i_clk) begin : monitor
        escaped_word_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (escaped_q.size() == 0) begin
                    flag_error($sformatf("unexpected word %02h", o_out_byte));
                end else begin
                    want = escaped_q.pop_front();
                    if (o_out_byte !== want.chr) begin
                        flag_error($sformatf("out_byte %02h, want %02h", o_out_byte, want.chr));
                    end
                    if (o_last_of_run !== want.last) begin
                        flag_error($sformatf("last_of_run %0b, want %0b",
                                             o_last_of_run, want.last));
                    end
                end
            end
            if (i_valid && o_ready) begin
                escape_byte(i_in_byte, i_end_of_string);
                words_in <= words_in + 1;
            end
            words_owed <= escaped_q.size();
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        logic [BYTE_W-1:0] escapes [8];
        logic [BYTE_W-1:0] lead;
        int                len;
        int                pick;
        int                directed_words;
        bit                drain_next;
        escapes = '{CHR_QUOTE, CHR_NEWLINE, CHR_RETURN, CHR_TAB,
                    CHR_BACKSPACE, CHR_FORMFEED, CHR_BACKSLASH, CHR_SLASH};

        // Directed part: plain bytes, every escape, a NUL, and each sequence corner.
        add_word(CHR_LOWER_A, 1'b0, 1'b0);
        add_word(CHR_TILDE, 1'b1, 1'b0);
        foreach (escapes[k]) add_word(escapes[k], 1'b0, 1'b0);
        add_word(CHR_NUL, 1'b0, 1'b0);
        // 0x7F is a lead byte of length two.
        add_word(8'h7F, 1'b0, 1'b0);
        add_word(8'hBF, 1'b0, 1'b0);
        // Single-byte sequence with all payload bits clear.
        add_word(8'h80, 1'b0, 1'b0);
        // All-ones lead with the smallest and largest continuations.
        add_word(8'hFF, 1'b0, 1'b0);
        add_word(8'h80, 1'b0, 1'b0);
        add_word(8'hBF, 1'b0, 1'b0);
        // ASCII arriving inside a pending sequence.
        add_word(8'hC3, 1'b0, 1'b0);
        add_word(8'h78, 1'b0, 1'b0);
        add_word(8'hA9, 1'b0, 1'b0);
        // End of string in the middle of a sequence drops it.
        add_word(8'hE2, 1'b0, 1'b0);
        add_word(8'h82, 1'b1, 1'b0);
        // A four-byte lead counts as three.
        add_word(8'hF0, 1'b0, 1'b0);
        add_word(8'h9F, 1'b0, 1'b0);
        add_word(8'h98, 1'b0, 1'b0);
        directed_words = string_q.size();

        // Random part: mostly multi-byte sequences, plain text, and some broken strings.
        drain_next = 1'b1;
        while (string_q.size() < directed_words + RANDOM_WORDS) begin
            if (string_q.size() == directed_words + RANDOM_WORDS / 2) begin
                drain_next = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                lead = BYTE_W'($urandom_range(8'h7F, 8'hFF));
                len = int'(lead[7]) + int'(lead[6]) + int'(lead[5]);
                add_word(lead, 1'b0, drain_next);
                for (int k = 1; k < len; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        add_word(BYTE_W'($urandom_range(1, 8'h7E)), 1'b0, 1'b0);
                    end
                    add_word(BYTE_W'($urandom_range(8'h7F, 8'hFF)),
                             (k == len - 1) && ($urandom_range(0, 7) == 0), 1'b0);
                end
            end else if (pick < 9) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_word(escapes[$urandom_range(0, 7)], $urandom_range(0, 9) == 0,
                             drain_next);
                end else begin
                    add_word(BYTE_W'($urandom_range(1, 8'h7E)), $urandom_range(0, 9) == 0,
                             drain_next);
                end
            end else begin
                // A long sequence cut short by the end of the string.
                add_word(BYTE_W'($urandom_range(8'hE0, 8'hFF)), 1'b0, drain_next);
                if ($urandom_range(0, 1) == 0) begin
                    add_word(BYTE_W'($urandom_range(8'h7F, 8'hFF)), 1'b1, 1'b0);
                end else begin
                    add_word(BYTE_W'($urandom_range(1, 8'h7E)), 1'b1, 1'b0);
                end
            end
            drain_next = 1'b0;
        end

        // Hold reset, then release it.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every result to come out, then settle.
        while (string_q.size() != 0 || i_valid || words_owed != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (escaped_q.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", escaped_q.size()));
        end
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
